// ===== hw/rtl/bus_servo_command_framer_macros.svh =====
// Assertion helpers shared by the framer RTL.
`ifndef BUS_SERVO_COMMAND_FRAMER_MACROS_SVH
`define BUS_SERVO_COMMAND_FRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is high.
`define BSF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Plain invariant, disabled while reset is high.
`define BSF_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`else
`define BSF_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define BSF_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`endif

`endif

// ===== hw/rtl/bsf_pkg.sv =====
`default_nettype none
package bsf_pkg;

   typedef enum logic [1:0] {
      MODE_MOVE   = 2'd0,
      MODE_LOAD   = 2'd1,
      MODE_UNLOAD = 2'd2,
      MODE_READ   = 2'd3
   } mode_type;

   localparam int POS_W   = 10;
   localparam int FRAME_MAX = 10;
   localparam int IDX_W   = $clog2(FRAME_MAX);
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      mode_type         mode;
      logic [7:0]       servo_id;
      logic [POS_W-1:0] position;
   } cmd_type;

   localparam logic [7:0] HDR_BYTE   = 8'h55;
   localparam logic [7:0] LEN_MOVE   = 8'h07;
   localparam logic [7:0] CMD_MOVE   = 8'h01;
   localparam logic [7:0] LEN_TORQUE = 8'h04;
   localparam logic [7:0] CMD_TORQUE = 8'h1F;
   localparam logic [7:0] TORQUE_ON  = 8'h01;
   localparam logic [7:0] TORQUE_OFF = 8'h00;
   localparam logic [7:0] LEN_READ   = 8'h03;
   localparam logic [7:0] CMD_READ   = 8'h1C;
   localparam logic [7:0] ZERO_BYTE  = 8'h00;

   // angle -> position: (angle + 120) * 1000 / 240 = (angle + 120) * 25 / 6
   localparam logic signed [16:0] ANGLE_OFFSET = 17'sd120;
   localparam logic signed [16:0] ANGLE_SPAN   = 17'sd240;
   localparam logic [POS_W-1:0]   POS_MAX      = 10'd1000;
   localparam logic [4:0]         POS_SCALE    = 5'd25;
   localparam logic [13:0]        RECIP_SIX    = 14'd10923;  // 2^16 / 6, rounded up
   localparam int                 RECIP_SHIFT  = 16;

   // byte positions in a frame
   localparam logic [IDX_W-1:0] BYTE_HDR0  = 4'd0;
   localparam logic [IDX_W-1:0] BYTE_HDR1  = 4'd1;
   localparam logic [IDX_W-1:0] BYTE_ID    = 4'd2;
   localparam logic [IDX_W-1:0] BYTE_LEN   = 4'd3;
   localparam logic [IDX_W-1:0] BYTE_CMD   = 4'd4;
   localparam logic [IDX_W-1:0] BYTE_P0    = 4'd5;
   localparam logic [IDX_W-1:0] BYTE_P1    = 4'd6;
   localparam logic [IDX_W-1:0] LAST_MOVE   = 4'd9;
   localparam logic [IDX_W-1:0] LAST_TORQUE = 4'd6;
   localparam logic [IDX_W-1:0] LAST_READ   = 4'd5;

endpackage
`default_nettype wire

// ===== hw/rtl/bsf_front.sv =====
`default_nettype none
module bsf_front (
   input  wire logic        [1:0]  req_mode,
   input  wire logic        [7:0]  req_servo_id,
   input  wire logic signed [15:0] req_angle,
   output bsf_pkg::cmd_type        cmd
);
   import bsf_pkg::*;

   logic signed [16:0] shifted;
   logic        [12:0] scaled;
   logic        [26:0] product;
   logic   [POS_W-1:0] position;

   always_comb begin
      shifted = 17'(req_angle) + ANGLE_OFFSET;
      scaled  = 13'(shifted[7:0]) * 13'(POS_SCALE);
      // divide by 6 through reciprocal; exact for scaled below 6000
      product = 27'(scaled) * 27'(RECIP_SIX);
      if (shifted <= 17'sd0) begin
         position = '0;
      end else if (shifted >= ANGLE_SPAN) begin
         position = POS_MAX;
      end else begin
         position = product[RECIP_SHIFT +: POS_W];
      end
      cmd.mode     = mode_type'(req_mode);
      cmd.servo_id = req_servo_id;
      cmd.position = position;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/bsf_queue.sv =====
`default_nettype none
`include "bus_servo_command_framer_macros.svh"
module bsf_queue #(
   parameter int DEPTH = bsf_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output      logic             full,
   input  wire bsf_pkg::cmd_type push_cmd,
   output      logic             head_valid,
   output bsf_pkg::cmd_type      head_cmd,
   input  wire logic             pop
);
   import bsf_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         entry_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            wr_en;
   logic            rd_en;

   always_comb begin
      full       = (count_ff == CW'(DEPTH)) || reset;
      head_valid = (count_ff != '0);
      head_cmd   = entry_ff[rd_ptr_ff];
      wr_en      = push_valid && !full;
      rd_en      = pop && head_valid;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `BSF_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "queue overfilled")
   `BSF_ASSERT_IMPL(a_pop_nonempty, clock, reset, pop, count_ff != '0, "pop from empty queue")
   `BSF_ASSERT_IMPL(a_ptr_gap, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff, "ptr mismatch")

endmodule
`default_nettype wire

// ===== hw/rtl/bsf_back.sv =====
`default_nettype none
`include "bus_servo_command_framer_macros.svh"
module bsf_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire bsf_pkg::cmd_type head_cmd,
   output      logic             pop,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      logic  [7:0]      rsp_frame_byte,
   output      logic             rsp_last_byte
);
   import bsf_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       sum_ff, sum_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic [IDX_W-1:0] last_idx;
   logic [7:0]       len_byte;
   logic [7:0]       cmd_byte;
   logic [7:0]       p0_byte;
   logic [7:0]       body_byte;
   logic             advance;
   logic             at_last;

   always_comb begin
      case (head_cmd.mode)
         MODE_MOVE: begin
            last_idx = LAST_MOVE;
            len_byte = LEN_MOVE;
            cmd_byte = CMD_MOVE;
            p0_byte  = head_cmd.position[7:0];
         end
         MODE_LOAD: begin
            last_idx = LAST_TORQUE;
            len_byte = LEN_TORQUE;
            cmd_byte = CMD_TORQUE;
            p0_byte  = TORQUE_ON;
         end
         MODE_UNLOAD: begin
            last_idx = LAST_TORQUE;
            len_byte = LEN_TORQUE;
            cmd_byte = CMD_TORQUE;
            p0_byte  = TORQUE_OFF;
         end
         default: begin
            last_idx = LAST_READ;
            len_byte = LEN_READ;
            cmd_byte = CMD_READ;
            p0_byte  = ZERO_BYTE;
         end
      endcase

      case (idx_ff)
         BYTE_HDR0: body_byte = HDR_BYTE;
         BYTE_HDR1: body_byte = HDR_BYTE;
         BYTE_ID:   body_byte = head_cmd.servo_id;
         BYTE_LEN:  body_byte = len_byte;
         BYTE_CMD:  body_byte = cmd_byte;
         BYTE_P0:   body_byte = p0_byte;
         BYTE_P1: begin
            body_byte = (head_cmd.mode == MODE_MOVE) ?
                        8'(head_cmd.position[POS_W-1:8]) : ZERO_BYTE;
         end
         default:   body_byte = ZERO_BYTE;
      endcase

      at_last = (idx_ff == last_idx);
      advance = head_valid && (!valid_ff || !rsp_stall);
      pop     = advance && at_last;

      idx_in   = idx_ff;
      sum_in   = sum_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      valid_in = valid_ff && rsp_stall;
      if (advance) begin
         valid_in = 1'b1;
         last_in  = at_last;
         byte_in  = at_last ? ~sum_ff : body_byte;
         if (at_last) begin
            idx_in = '0;
            sum_in = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
            // checksum covers id onward
            if (idx_ff >= BYTE_ID) begin
               sum_in = sum_ff + body_byte;
            end
         end
      end

      rsp_valid      = valid_ff;
      rsp_frame_byte = byte_ff;
      rsp_last_byte  = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         sum_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   `BSF_ASSERT_ALWAYS(a_idx_bound, clock, reset, idx_ff <= LAST_MOVE, "byte index out of range")
   `BSF_ASSERT_IMPL(a_mid_frame_head, clock, reset, idx_ff != '0, head_valid, "frame lost head")
   `BSF_ASSERT_IMPL(a_pop_at_end, clock, reset, pop, advance && at_last, "pop before frame end")

endmodule
`default_nettype wire

// ===== hw/rtl/bus_servo_command_framer.sv =====
`default_nettype none
// Bus-servo command framer. Each accepted item (mode, servo id, angle) becomes
// one byte frame on the rsp channel, one byte per item there: 10 bytes for a
// move, 7 for torque load/unload, 6 for a position read; rsp_last_byte marks
// the checksum byte. Commands are classified on entry and held in a small
// queue (QUEUE_DEPTH entries) ahead of the byte sequencer, so the block takes
// a new command while an earlier frame is still going out. The first byte
// passes through the queue and the sequencer's output register; throughput is
// set by the sequencer's one byte per cycle while rsp_stall is low.
module bus_servo_command_framer #(
   parameter int QUEUE_DEPTH = bsf_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic        [1:0]  req_mode,
   input  wire logic        [7:0]  req_servo_id,
   input  wire logic signed [15:0] req_angle,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic        [7:0]  rsp_frame_byte,
   output      logic               rsp_last_byte
);
   import bsf_pkg::*;

   cmd_type new_cmd;
   cmd_type head_cmd;
   logic    head_valid;
   logic    pop;

   bsf_front u_front (
      .req_mode     (req_mode),
      .req_servo_id (req_servo_id),
      .req_angle    (req_angle),
      .cmd          (new_cmd)
   );

   bsf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .full       (req_stall),
      .push_cmd   (new_cmd),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   bsf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule
`default_nettype wire

// ===== sim/bus_servo_command_framer_tb.sv =====
module bus_servo_command_framer_tb;
   import bsf_pkg::*;

   localparam int IDLE_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 30;
   localparam int SEG_ITEMS = 40;
   localparam int SEG_COUNT = 11;

   // Expected frame bytes, filled from accepted commands, drained by rsp items.
   class frame_scoreboard;
      typedef struct {
         logic [7:0] data;
         logic       is_last;
      } frame_byte_type;

      frame_byte_type expected_bytes[$];
      int             errors;

      function int pending();
         return expected_bytes.size();
      endfunction

      function void push_byte(logic [7:0] data, logic is_last);
         expected_bytes.push_back('{data: data, is_last: is_last});
      endfunction

      function void note_command(mode_type mode, logic [7:0] servo_id,
                                 logic signed [15:0] angle);
         logic [7:0] body[$];
         logic [7:0] sum;
         logic [9:0] pos;
         int         scaled;
         body.push_back(servo_id);
         case (mode)
            MODE_MOVE: begin
               // integer division truncates toward zero, then clamp
               scaled = (int'(angle) + 120) * 1000 / 240;
               if (scaled < 0) scaled = 0;
               if (scaled > 1000) scaled = 1000;
               pos = scaled[9:0];
               body.push_back(LEN_MOVE);
               body.push_back(CMD_MOVE);
               body.push_back(pos[7:0]);
               body.push_back({6'b0, pos[9:8]});
               body.push_back(ZERO_BYTE);
               body.push_back(ZERO_BYTE);
            end
            MODE_LOAD, MODE_UNLOAD: begin
               body.push_back(LEN_TORQUE);
               body.push_back(CMD_TORQUE);
               body.push_back(mode == MODE_LOAD ? TORQUE_ON : TORQUE_OFF);
            end
            default: begin
               body.push_back(LEN_READ);
               body.push_back(CMD_READ);
            end
         endcase
         push_byte(HDR_BYTE, 1'b0);
         push_byte(HDR_BYTE, 1'b0);
         sum = '0;
         foreach (body[i]) begin
            sum += body[i];
            push_byte(body[i], 1'b0);
         end
         push_byte(~sum, 1'b1);
      endfunction

      function void check_byte(logic [7:0] data, logic is_last);
         frame_byte_type exp;
         if (expected_bytes.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected byte %02h last=%0b with nothing pending", data, is_last);
            return;
         end
         exp = expected_bytes.pop_front();
         if (data !== exp.data || is_last !== exp.is_last) begin
            errors++;
            if (errors <= 10)
               $display("byte mismatch: expected %02h last=%0b, got %02h last=%0b",
                        exp.data, exp.is_last, data, is_last);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic        [1:0]  req_mode = '0;
   logic        [7:0]  req_servo_id = '0;
   logic signed [15:0] req_angle = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic        [7:0]  rsp_frame_byte;
   logic               rsp_last_byte;

   frame_scoreboard sb = new();
   bit send_dense = 1'b0;
   bit recv_dense = 1'b0;
   bit long_hold = 1'b0;
   int idle_cycles = 0;

   bus_servo_command_framer u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_servo_id  (req_servo_id),
      .req_angle     (req_angle),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_last_byte (rsp_last_byte)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Handshake monitor: values seen here are the ones before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_command(mode_type'(req_mode), req_servo_id, req_angle);
         if (rsp_valid && !rsp_stall)
            sb.check_byte(rsp_frame_byte, rsp_last_byte);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic send_command(input mode_type mode, input logic [7:0] servo_id,
                               input logic signed [15:0] angle);
      int gap;
      gap = send_dense ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_servo_id <= servo_id;
      req_angle    <= angle;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic signed [15:0] pick_angle();
      int edges[9] = '{-32768, 32767, -121, -120, -119, 119, 120, 121, 0};
      int sel;
      int v;
      sel = $urandom_range(0, 3);
      case (sel)
         0: begin
            v = $urandom;
            return v[15:0];
         end
         1: begin
            v = $urandom_range(0, 280);
            return 16'(v - 140);
         end
         2: begin
            v = $urandom_range(0, 2000);
            return 16'(v - 1000);
         end
         default: return 16'(edges[$urandom_range(0, 8)]);
      endcase
   endfunction

   // Result side: per-item random stall, plus one long hold on request.
   initial begin : rsp_side
      int w;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end
         w = recv_dense ? 0 : $urandom_range(0, 15);
         if (w > 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : req_side
      int seg;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // clamp edges, truncation near zero, full-scale angles
      send_command(MODE_MOVE, 8'h00, -16'sd32768);
      send_command(MODE_MOVE, 8'hFF, 16'sd32767);
      send_command(MODE_MOVE, 8'h01, -16'sd121);
      send_command(MODE_MOVE, 8'h02, -16'sd120);
      send_command(MODE_MOVE, 8'h03, -16'sd119);
      send_command(MODE_MOVE, 8'h04, -16'sd1);
      send_command(MODE_MOVE, 8'h05, 16'sd0);
      send_command(MODE_MOVE, 8'h06, 16'sd1);
      send_command(MODE_MOVE, 8'h07, 16'sd119);
      send_command(MODE_MOVE, 8'h08, 16'sd120);
      send_command(MODE_MOVE, 8'h09, 16'sd121);
      send_command(MODE_MOVE, 8'hFE, 16'sd45);
      // angle must be ignored by the other commands
      send_command(MODE_LOAD, 8'h00, 16'sd32767);
      send_command(MODE_LOAD, 8'hFF, -16'sd32768);
      send_command(MODE_UNLOAD, 8'hFE, -16'sd1);
      send_command(MODE_UNLOAD, 8'h00, 16'sd0);
      send_command(MODE_READ, 8'hFF, 16'sh5555);
      send_command(MODE_READ, 8'h00, -16'sd21846);
      send_command(MODE_READ, 8'hFE, 16'sd120);
      send_command(MODE_MOVE, 8'hAA, 16'sd500);

      for (seg = 0; seg < SEG_COUNT; seg++) begin
         send_dense = (seg % 3 == 1);
         recv_dense = (seg % 4 == 2);
         if (seg == 5) begin
            // receiver holds off while commands keep coming
            send_dense = 1'b1;
            long_hold = 1'b1;
         end
         repeat (SEG_ITEMS)
            send_command(mode_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         pick_angle());
      end
      req_valid <= 1'b0;

      // advance the clock before the first check so the monitor has noted the last command
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
